FILE: rtl/dpc_pkg.sv
package dpc_pkg;

    localparam int COORD_W    = 10;
    localparam int GREY_W     = 8;
    localparam int DUTY_W     = 7;
    localparam int SUM_W      = 30;
    localparam int CNT_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DUTY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY      = 3'd4;

    localparam logic [GREY_W-1:0]  RST_DARK_THRESHOLD = 8'd100;
    localparam logic [COORD_W-1:0] RST_LEFT_LIMIT     = 10'd315;
    localparam logic [COORD_W-1:0] RST_RIGHT_LIMIT    = 10'd325;
    localparam logic [DUTY_W-1:0]  RST_FAST_DUTY      = 7'd20;
    localparam logic [DUTY_W-1:0]  RST_SLOW_DUTY      = 7'd10;

    typedef enum logic [1:0] {
        STEER_LEFT    = 2'd0,
        STEER_FORWARD = 2'd1,
        STEER_RIGHT   = 2'd2,
        STEER_BACK    = 2'd3
    } t_steer;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD_X,
        ST_DIV_X,
        ST_LOAD_Y,
        ST_DIV_Y,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic div_load;
        logic div_sel_y;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_accept;
        logic in_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/dpc_pix_if.sv
interface dpc_pix_if;
    logic                              valid;
    logic                              ready;
    logic [dpc_pkg::COORD_W-1:0]       pixel_x;
    logic [dpc_pkg::COORD_W-1:0]       pixel_y;
    logic [dpc_pkg::GREY_W-1:0]        grey_level;
    logic                              frame_end;

    modport source (output valid, pixel_x, pixel_y, grey_level, frame_end, input ready);
    modport sink (input valid, pixel_x, pixel_y, grey_level, frame_end, output ready);
endinterface

FILE: rtl/dpc_res_if.sv
interface dpc_res_if;
    logic                              valid;
    logic                              ready;
    logic [dpc_pkg::COORD_W-1:0]       centroid_x;
    logic [dpc_pkg::COORD_W-1:0]       centroid_y;
    logic                              line_found;
    logic [1:0]                        steer_code;
    logic [dpc_pkg::DUTY_W-1:0]        left_duty;
    logic [dpc_pkg::DUTY_W-1:0]        right_duty;
    logic                              left_dir;
    logic                              right_dir;

    modport source (
        output valid, centroid_x, centroid_y, line_found, steer_code,
               left_duty, right_duty, left_dir, right_dir,
        input  ready
    );
    modport sink (
        input  valid, centroid_x, centroid_y, line_found, steer_code,
               left_duty, right_duty, left_dir, right_dir,
        output ready
    );
endinterface

FILE: rtl/dark_pixel_centroid_steering.sv
// A pixel request that does not end a frame is taken one per clock while the block accumulates.
// A frame-end request is followed by an x division and then a y division on one shared
// restoring divider, each after a load of its dividend. Pixel input is held off during
// the divisions and until the result register can take the finished result, which is
// then loaded into the result register as the sums are cleared.
// Synchronous active-low reset restores the register defaults and clears the sums.
module dark_pixel_centroid_steering #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dpc_pix_if.sink                           i_pix,
    dpc_res_if.source                         o_res
);

    dpc_pkg::t_cmd    w_cmd;
    dpc_pkg::t_status w_status;

    dpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    dpc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_pix      (i_pix),
        .o_res      (o_res)
    );

endmodule

FILE: rtl/dpc_ctrl.sv
module dpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dpc_pkg::t_status i_status,
    output dpc_pkg::t_cmd    o_cmd
);

    localparam logic [dpc_pkg::STEP_W-1:0] LAST_STEP = dpc_pkg::STEP_W'(dpc_pkg::DIV_STEPS - 1);

    dpc_pkg::t_state              r_state, n_state;
    logic [dpc_pkg::STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpc_pkg::ST_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            dpc_pkg::ST_ACCUM: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_accept && i_status.in_last) begin
                    n_state = dpc_pkg::ST_LOAD_X;
                end
            end
            dpc_pkg::ST_LOAD_X: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = dpc_pkg::ST_DIV_X;
            end
            dpc_pkg::ST_DIV_X: begin
                o_cmd.div_step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = dpc_pkg::ST_LOAD_Y;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            dpc_pkg::ST_LOAD_Y: begin
                o_cmd.div_load  = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_step          = '0;
                n_state         = dpc_pkg::ST_DIV_Y;
            end
            dpc_pkg::ST_DIV_Y: begin
                o_cmd.div_step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = dpc_pkg::ST_RESULT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            dpc_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dpc_pkg::ST_ACCUM;
                end
            end
            default: begin
                n_state = dpc_pkg::ST_ACCUM;
            end
        endcase
    end

    a_div_x_then_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpc_pkg::ST_DIV_X && r_step == LAST_STEP) |=>
            (r_state == dpc_pkg::ST_LOAD_Y))
        else $error("x division did not hand over to y division");

    a_frame_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.in_ready && i_status.in_accept && i_status.in_last) |=>
            (r_state == dpc_pkg::ST_LOAD_X))
        else $error("frame end request did not start the division");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpc_pkg::ST_RESULT && !i_status.out_free) |=>
            (r_state == dpc_pkg::ST_RESULT))
        else $error("finished result left before the result register was free");

endmodule

FILE: rtl/dpc_datapath.sv
module dpc_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  dpc_pkg::t_cmd                     i_cmd,
    output dpc_pkg::t_status                  o_status,
    dpc_pix_if.sink                           i_pix,
    dpc_res_if.source                         o_res
);

    localparam int CW = dpc_pkg::COORD_W;
    localparam int SW = dpc_pkg::SUM_W;
    localparam int NW = dpc_pkg::CNT_W;
    localparam int DW = dpc_pkg::DUTY_W;

    logic [dpc_pkg::GREY_W-1:0] r_thr;
    logic [CW-1:0]              r_left_lim;
    logic [CW-1:0]              r_right_lim;
    logic [DW-1:0]              r_fast;
    logic [DW-1:0]              r_slow;

    logic [SW-1:0]              r_sum_x;
    logic [SW-1:0]              r_sum_y;
    logic [NW-1:0]              r_cnt;

    logic [SW-1:0]              r_quo;
    logic [NW-1:0]              r_rem;
    logic [CW-1:0]              r_cx;

    logic                       r_out_valid;
    logic [CW-1:0]              r_out_cx;
    logic [CW-1:0]              r_out_cy;
    logic                       r_out_found;
    dpc_pkg::t_steer            r_out_steer;
    logic [DW-1:0]              r_out_ld;
    logic [DW-1:0]              r_out_rd;
    logic                       r_out_ldir;
    logic                       r_out_rdir;

    logic                       w_accept;
    logic                       w_dark;
    logic [NW:0]                w_shift;
    logic [NW:0]                w_diff;
    logic                       w_ge;
    logic                       w_found;
    logic [CW-1:0]              w_cy;
    dpc_pkg::t_steer            w_steer;
    logic [DW-1:0]              w_ld;
    logic [DW-1:0]              w_rd;

    assign i_pix.ready = i_cmd.in_ready;
    assign w_accept    = i_pix.valid && i_cmd.in_ready;
    assign w_dark      = (i_pix.grey_level < r_thr)
                      && (32'(i_pix.pixel_x) < 32'(MAX_WIDTH))
                      && (32'(i_pix.pixel_y) < 32'(MAX_HEIGHT));

    assign o_status.in_accept = w_accept;
    assign o_status.in_last   = i_pix.frame_end;
    assign o_status.out_free  = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= dpc_pkg::RST_DARK_THRESHOLD;
            r_left_lim  <= dpc_pkg::RST_LEFT_LIMIT;
            r_right_lim <= dpc_pkg::RST_RIGHT_LIMIT;
            r_fast      <= dpc_pkg::RST_FAST_DUTY;
            r_slow      <= dpc_pkg::RST_SLOW_DUTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpc_pkg::CFG_DARK_THRESHOLD: r_thr       <= i_cfg_data[dpc_pkg::GREY_W-1:0];
                dpc_pkg::CFG_LEFT_LIMIT:     r_left_lim  <= i_cfg_data[CW-1:0];
                dpc_pkg::CFG_RIGHT_LIMIT:    r_right_lim <= i_cfg_data[CW-1:0];
                dpc_pkg::CFG_FAST_DUTY:      r_fast      <= i_cfg_data[DW-1:0];
                dpc_pkg::CFG_SLOW_DUTY:      r_slow      <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.out_load) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_cnt   <= '0;
        end else if (w_accept && w_dark) begin
            r_sum_x <= r_sum_x + SW'(i_pix.pixel_x);
            r_sum_y <= r_sum_y + SW'(i_pix.pixel_y);
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign w_shift = {r_rem, r_quo[SW-1]};
    assign w_diff  = w_shift - {1'b0, r_cnt};
    assign w_ge    = (w_shift >= {1'b0, r_cnt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= i_cmd.div_sel_y ? r_sum_y : r_sum_x;
            r_rem <= '0;
            if (i_cmd.div_sel_y) begin
                r_cx <= r_quo[CW-1:0];
            end
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[NW-1:0] : w_shift[NW-1:0];
        end
    end

    assign w_found = (r_cnt != '0);
    assign w_cy    = r_quo[CW-1:0];

    always_comb begin
        if (!w_found) begin
            w_steer = dpc_pkg::STEER_BACK;
            w_ld    = r_slow;
            w_rd    = r_slow;
        end else if (r_cx >= r_right_lim) begin
            w_steer = dpc_pkg::STEER_RIGHT;
            w_ld    = r_fast;
            w_rd    = r_slow;
        end else if (r_cx <= r_left_lim) begin
            w_steer = dpc_pkg::STEER_LEFT;
            w_ld    = r_slow;
            w_rd    = r_fast;
        end else begin
            w_steer = dpc_pkg::STEER_FORWARD;
            w_ld    = r_fast;
            w_rd    = r_fast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cx    <= w_found ? r_cx : '0;
            r_out_cy    <= w_found ? w_cy : '0;
            r_out_found <= w_found;
            r_out_steer <= w_steer;
            r_out_ld    <= w_ld;
            r_out_rd    <= w_rd;
            r_out_ldir  <= w_found;
            r_out_rdir  <= !w_found;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.centroid_x = r_out_cx;
    assign o_res.centroid_y = r_out_cy;
    assign o_res.line_found = r_out_found;
    assign o_res.steer_code = r_out_steer;
    assign o_res.left_duty  = r_out_ld;
    assign o_res.right_duty = r_out_rd;
    assign o_res.left_dir   = r_out_ldir;
    assign o_res.right_dir  = r_out_rdir;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten before it was taken");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_cnt == '0 && r_sum_x == '0 && r_sum_y == '0))
        else $error("accumulators not cleared after the result");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |->
            (r_out_cx == '0 && r_out_cy == '0 && r_out_steer == dpc_pkg::STEER_BACK))
        else $error("not-found result carries a centroid or a wrong steer code");

endmodule
